// File: hdl/tdkd_pkg.sv
// Shared types, constants and register codes for the tick divider and key debouncer.
`timescale 1ns / 1ps
`default_nettype none

package tdkd_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_NUM_KEYS   = 5;
    localparam int DEF_TICK_WIDTH = 16;
    localparam int DEF_HOLD_WIDTH = 8;

    // Configuration port
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int PERIOD_WIDTH    = 16;
    localparam int LIMIT_WIDTH     = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TICKS_PER_WRAP    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TICKS_FAST_PERIOD = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TICKS_SLOW_PERIOD = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_LIMIT    = 2'd3;

    localparam logic [PERIOD_WIDTH-1:0] RST_TICKS_PER_WRAP    = 16'd20000;
    localparam logic [PERIOD_WIDTH-1:0] RST_TICKS_FAST_PERIOD = 16'd200;
    localparam logic [PERIOD_WIDTH-1:0] RST_TICKS_SLOW_PERIOD = 16'd2000;
    localparam logic [LIMIT_WIDTH-1:0]  RST_DEBOUNCE_LIMIT    = 8'd5;

    // Slow-pulse dividers
    localparam int HALF_SECOND_DIV  = 5;
    localparam int SECOND_DIV       = 10;
    localparam int HALF_CNT_WIDTH   = $clog2(HALF_SECOND_DIV);
    localparam int SECOND_CNT_WIDTH = $clog2(SECOND_DIV);

    // Buttons sit above the switch in the key vector
    localparam int BUTTON_COUNT = 4;

    // Pulses produced for one transaction
    typedef struct packed {
        logic fast;
        logic slow;
        logic half_second;
        logic second;
    } pulse_t;

endpackage

`default_nettype wire

// File: hdl/tdkd_tick_divider.sv
// Fast/slow tick marks with wrap-corrected elapsed compare and slow-pulse dividers.
`timescale 1ns / 1ps
`default_nettype none

module tdkd_tick_divider #(
    parameter int TICK_WIDTH = tdkd_pkg::DEF_TICK_WIDTH
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             step,
    input  wire logic [TICK_WIDTH-1:0]            tick,
    input  wire logic [tdkd_pkg::PERIOD_WIDTH-1:0] ticks_per_wrap,
    input  wire logic [tdkd_pkg::PERIOD_WIDTH-1:0] fast_period,
    input  wire logic [tdkd_pkg::PERIOD_WIDTH-1:0] slow_period,
    output tdkd_pkg::pulse_t                      pulses
);
    import tdkd_pkg::*;

    // Room for tick + modulus plus a borrow bit
    localparam int BASE_WIDTH = (TICK_WIDTH > PERIOD_WIDTH) ? TICK_WIDTH : PERIOD_WIDTH;
    localparam int EW         = BASE_WIDTH + 2;

    logic [TICK_WIDTH-1:0]       fast_mark_reg, fast_mark_next;
    logic [TICK_WIDTH-1:0]       slow_mark_reg, slow_mark_next;
    logic [HALF_CNT_WIDTH-1:0]   half_cnt_reg, half_cnt_next;
    logic [SECOND_CNT_WIDTH-1:0] sec_cnt_reg, sec_cnt_next;
    logic [HALF_CNT_WIDTH:0]     half_inc;
    logic [SECOND_CNT_WIDTH:0]   sec_inc;

    // Elapsed ticks since a mark exceed the period; a borrow reads as huge and fires
    function automatic logic past_period(input logic [TICK_WIDTH-1:0]   t,
                                         input logic [TICK_WIDTH-1:0]   m,
                                         input logic [PERIOD_WIDTH-1:0] wrap,
                                         input logic [PERIOD_WIDTH-1:0] period);
        logic [EW-1:0] d;
        if (t >= m) begin
            d = EW'(t) - EW'(m);
        end else begin
            d = EW'(t) + EW'(wrap) - EW'(m);
        end
        return d > EW'(period);
    endfunction

    // Pulse decisions for the current transaction
    always_comb begin
        pulses.fast = past_period(tick, fast_mark_reg, ticks_per_wrap, fast_period);
        pulses.slow = past_period(tick, slow_mark_reg, ticks_per_wrap, slow_period);

        half_inc = (HALF_CNT_WIDTH + 1)'(half_cnt_reg) + 1'b1;
        sec_inc  = (SECOND_CNT_WIDTH + 1)'(sec_cnt_reg) + 1'b1;

        pulses.half_second = pulses.slow && (half_inc >= (HALF_CNT_WIDTH + 1)'(HALF_SECOND_DIV));
        pulses.second      = pulses.slow && (sec_inc >= (SECOND_CNT_WIDTH + 1)'(SECOND_DIV));

        fast_mark_next = pulses.fast ? tick : fast_mark_reg;
        slow_mark_next = pulses.slow ? tick : slow_mark_reg;

        half_cnt_next = half_cnt_reg;
        sec_cnt_next  = sec_cnt_reg;
        if (pulses.slow) begin
            half_cnt_next = pulses.half_second ? '0 : half_inc[HALF_CNT_WIDTH-1:0];
            sec_cnt_next  = pulses.second ? '0 : sec_inc[SECOND_CNT_WIDTH-1:0];
        end
    end

    // State advances once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_mark_reg <= '0;
            slow_mark_reg <= '0;
            half_cnt_reg  <= '0;
            sec_cnt_reg   <= '0;
        end else if (step) begin
            fast_mark_reg <= fast_mark_next;
            slow_mark_reg <= slow_mark_next;
            half_cnt_reg  <= half_cnt_next;
            sec_cnt_reg   <= sec_cnt_next;
        end
    end

    // Dividers stay in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        half_cnt_reg < HALF_CNT_WIDTH'(HALF_SECOND_DIV))
        else $error("half-second counter out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        sec_cnt_reg < SECOND_CNT_WIDTH'(SECOND_DIV))
        else $error("second counter out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        pulses.second |-> pulses.half_second)
        else $error("second pulse without half-second pulse");

endmodule

`default_nettype wire

// File: hdl/tdkd_key_debouncer.sv
// Per-key hold counters, press detection, level capture and button latch.
`timescale 1ns / 1ps
`default_nettype none

module tdkd_key_debouncer #(
    parameter int NUM_KEYS   = tdkd_pkg::DEF_NUM_KEYS,
    parameter int HOLD_WIDTH = tdkd_pkg::DEF_HOLD_WIDTH
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             step,
    input  wire logic                             scan,
    input  wire logic [NUM_KEYS-1:0]              levels,
    input  wire logic [tdkd_pkg::LIMIT_WIDTH-1:0] limit,
    output logic      [NUM_KEYS-1:0]              events,
    output logic      [tdkd_pkg::BUTTON_COUNT-1:0] latch_next,
    output logic      [NUM_KEYS-1:0]              capture_next
);
    import tdkd_pkg::*;

    localparam int CW = (HOLD_WIDTH > LIMIT_WIDTH) ? HOLD_WIDTH : LIMIT_WIDTH;
    localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = '1;
    localparam int EVW = NUM_KEYS + BUTTON_COUNT;

    logic [HOLD_WIDTH-1:0]   hold_reg [NUM_KEYS];
    logic [HOLD_WIDTH-1:0]   hold_next [NUM_KEYS];
    logic [NUM_KEYS-1:0]     capture_reg;
    logic [BUTTON_COUNT-1:0] latch_reg;
    logic [EVW-1:0]          events_wide;
    logic [HOLD_WIDTH-1:0]   hold_inc [NUM_KEYS];

    // Hold counters: count held scans, saturate past the limit, clear on release
    always_comb begin
        events = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            hold_inc[k]  = hold_reg[k] + 1'b1;
            hold_next[k] = hold_reg[k];
            if (scan) begin
                if (levels[k]) begin
                    if ((CW'(hold_reg[k]) <= CW'(limit)) && (hold_reg[k] < HOLD_MAX)) begin
                        hold_next[k] = hold_inc[k];
                        events[k]    = (CW'(hold_inc[k]) == CW'(limit));
                    end
                end else begin
                    hold_next[k] = '0;
                end
            end
        end
    end

    // Buttons sit above the switch; keys beyond NUM_KEYS read as zero
    assign events_wide  = EVW'(events);
    assign latch_next   = scan ? events_wide[BUTTON_COUNT:1] : latch_reg;
    assign capture_next = scan ? levels : capture_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                hold_reg[k] <= '0;
            end
            capture_reg <= '0;
            latch_reg   <= '0;
        end else if (step) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                hold_reg[k] <= hold_next[k];
            end
            capture_reg <= capture_next;
            latch_reg   <= latch_next;
        end
    end

    // Press only on a scan of a held key
    assert property (@(posedge aclk) disable iff (!aresetn)
        (|events) |-> scan)
        else $error("press event outside a scan");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (events & ~levels) == '0)
        else $error("press event on a released key");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (limit == '0) |-> (events == '0))
        else $error("press event with zero debounce limit");

endmodule

`default_nettype wire

// File: hdl/tick_divider_key_debouncer.sv
// Top level: input register, tick divider, key debouncer and result register.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------
//  input   | s_tick_count, s_key_levels              | s_valid / s_ready
//  result  | m_pulse_*, m_press_*, m_sampled_levels  | m_valid / m_ready
//  config  | cfg_addr, cfg_wdata                     | cfg_we, no wait
//
// One transaction per cycle sustained while m_ready stays high; m_valid rises once
// the transaction has passed from the input register into the result register.
// State is updated as a transaction moves from the input register to the result
// register, so transactions are processed strictly in order.
// A stalled result holds the result register; the input register still takes one
// more transaction, after which s_ready drops until the result is taken.
// Reset is synchronous and active low; it takes effect with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module tick_divider_key_debouncer #(
    parameter int NUM_KEYS   = tdkd_pkg::DEF_NUM_KEYS,
    parameter int TICK_WIDTH = tdkd_pkg::DEF_TICK_WIDTH,
    parameter int HOLD_WIDTH = tdkd_pkg::DEF_HOLD_WIDTH
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration
    input  wire logic                                 cfg_we,
    input  wire logic [tdkd_pkg::CFG_INDEX_WIDTH-1:0] cfg_addr,
    input  wire logic [tdkd_pkg::CFG_WIDTH-1:0]       cfg_wdata,
    // input channel
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [TICK_WIDTH-1:0]                s_tick_count,
    input  wire logic [NUM_KEYS-1:0]                  s_key_levels,
    // result channel
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_pulse_fast,
    output logic                                      m_pulse_slow,
    output logic                                      m_pulse_half_second,
    output logic                                      m_pulse_second,
    output logic      [NUM_KEYS-1:0]                  m_press_events,
    output logic      [tdkd_pkg::BUTTON_COUNT-1:0]    m_press_latched,
    output logic      [NUM_KEYS-1:0]                  m_sampled_levels
);
    import tdkd_pkg::*;

    logic [PERIOD_WIDTH-1:0] ticks_per_wrap_reg;
    logic [PERIOD_WIDTH-1:0] fast_period_reg;
    logic [PERIOD_WIDTH-1:0] slow_period_reg;
    logic [LIMIT_WIDTH-1:0]  debounce_limit_reg;

    logic                    in_valid_reg;
    logic [TICK_WIDTH-1:0]   tick_reg;
    logic [NUM_KEYS-1:0]     levels_reg;

    logic                    out_valid_reg;
    pulse_t                  pulses_reg;
    logic [NUM_KEYS-1:0]     events_reg;
    logic [BUTTON_COUNT-1:0] latched_reg;
    logic [NUM_KEYS-1:0]     sampled_reg;

    logic                    advance;
    pulse_t                  pulses;
    logic [NUM_KEYS-1:0]     events;
    logic [BUTTON_COUNT-1:0] latch_next;
    logic [NUM_KEYS-1:0]     capture_next;

    // Handshake: move a transaction forward when the result slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_wrap_reg <= RST_TICKS_PER_WRAP;
            fast_period_reg    <= RST_TICKS_FAST_PERIOD;
            slow_period_reg    <= RST_TICKS_SLOW_PERIOD;
            debounce_limit_reg <= RST_DEBOUNCE_LIMIT;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TICKS_PER_WRAP:    ticks_per_wrap_reg <= cfg_wdata[PERIOD_WIDTH-1:0];
                REG_TICKS_FAST_PERIOD: fast_period_reg    <= cfg_wdata[PERIOD_WIDTH-1:0];
                REG_TICKS_SLOW_PERIOD: slow_period_reg    <= cfg_wdata[PERIOD_WIDTH-1:0];
                REG_DEBOUNCE_LIMIT:    debounce_limit_reg <= cfg_wdata[LIMIT_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload is cleared on reset so the datapath never carries unknowns
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg   <= '0;
            levels_reg <= '0;
        end else if (s_valid && s_ready) begin
            tick_reg   <= s_tick_count;
            levels_reg <= s_key_levels;
        end
    end

    tdkd_tick_divider #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_divider (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .tick           (tick_reg),
        .ticks_per_wrap (ticks_per_wrap_reg),
        .fast_period    (fast_period_reg),
        .slow_period    (slow_period_reg),
        .pulses         (pulses)
    );

    tdkd_key_debouncer #(
        .NUM_KEYS   (NUM_KEYS),
        .HOLD_WIDTH (HOLD_WIDTH)
    ) u_debouncer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .scan         (pulses.fast),
        .levels       (levels_reg),
        .limit        (debounce_limit_reg),
        .events       (events),
        .latch_next   (latch_next),
        .capture_next (capture_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pulses_reg  <= pulses;
            events_reg  <= events;
            latched_reg <= latch_next;
            sampled_reg <= capture_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_pulse_fast        = pulses_reg.fast;
    assign m_pulse_slow        = pulses_reg.slow;
    assign m_pulse_half_second = pulses_reg.half_second;
    assign m_pulse_second      = pulses_reg.second;
    assign m_press_events      = events_reg;
    assign m_press_latched     = latched_reg;
    assign m_sampled_levels    = sampled_reg;

    // Result consistency and flow
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pulse_half_second) |-> m_pulse_slow)
        else $error("half-second pulse without slow pulse");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_press_events != '0)) |-> m_pulse_fast)
        else $error("press event without a scan");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && in_valid_reg) |=> in_valid_reg)
        else $error("input register overwritten while result stalled");

endmodule

`default_nettype wire
